// ===== rtl/c2dzp_pkg.sv =====
`default_nettype none

package c2dzp_pkg;

  // Store dimensions.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_KERNEL = 7;

  // Field widths.
  localparam int ACT_W   = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int DIM_W   = 7;
  localparam int KDIM_W  = 3;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 7;

  // Derived widths.
  localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam int KER_AW    = $clog2(KER_DEPTH);
  localparam int KIDX_W    = $clog2(MAX_KERNEL + 1);
  localparam int COORD_W   = ROW_W + 2;
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int ACC_W     = PROD_W + $clog2(KER_DEPTH) + 1;
  localparam int SHIFT_W   = ACC_W - FRAC_W;

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_LOAD_IMG = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_KER = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE     = 2'd3;

  // Configuration register indices.
  localparam logic [CFG_IW-1:0] CFG_IMG_W = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IMG_H = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_KER_W = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_KER_H = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] pixel_out;
    logic                      saturated;
  } out_item_t;

  // Store write command from the sequencer.
  typedef struct packed {
    logic                      img_we;
    logic                      ker_we;
    logic [IMG_AW-1:0]         img_addr;
    logic [KER_AW-1:0]         ker_addr;
    logic signed [VALUE_W-1:0] data;
  } wr_cmd_t;

  // One kernel tap issued to the stores.
  typedef struct packed {
    logic              valid;
    logic [IMG_AW-1:0] img_addr;
    logic [KER_AW-1:0] ker_addr;
  } tap_t;

  // Operand pair read back from the stores.
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] img;
    logic signed [VALUE_W-1:0] ker;
  } rd_t;

  // Accumulator control.
  typedef struct packed {
    logic clear;
    logic finish;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/c2dzp_seq.sv =====
`default_nettype none

module c2dzp_seq import c2dzp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_data,
  input  wire logic              cfg_valid,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  output wr_cmd_t                wr_cmd,
  output tap_t                   tap,
  output mac_ctl_t               mac_ctl
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  // Drain count at which the accumulator holds the full sum.
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        drain_r, drain_nxt;
  logic [KIDX_W-1:0] kx_r, kx_nxt;
  logic [KIDX_W-1:0] ky_r, ky_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  iw_r, ih_r;
  logic [KDIM_W-1:0] kw_r, kh_r;

  logic [DIM_W-1:0]          iw_eff, ih_eff;
  logic [KDIM_W-1:0]         kw_eff, kh_eff;
  logic [KDIM_W-1:0]         ax, ay;
  logic signed [COORD_W-1:0] ty, tx;
  logic                      tap_in_img;
  logic                      accept;
  logic                      last_tap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= DIM_W'(64);
      ih_r <= DIM_W'(64);
      kw_r <= KDIM_W'(3);
      kh_r <= KDIM_W'(3);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMG_W: iw_r <= cfg_data;
        CFG_IMG_H: ih_r <= cfg_data;
        CFG_KER_W: kw_r <= cfg_data[KDIM_W-1:0];
        CFG_KER_H: kh_r <= cfg_data[KDIM_W-1:0];
        default:   iw_r <= iw_r;
      endcase
    end
  end

  // Register values outside their range are pulled to the nearest bound.
  always_comb begin
    iw_eff = iw_r;
    ih_eff = ih_r;
    kw_eff = kw_r;
    kh_eff = kh_r;
    if (iw_r == '0) iw_eff = DIM_W'(1);
    else if (32'(iw_r) > 32'(MAX_WIDTH)) iw_eff = DIM_W'(MAX_WIDTH);
    if (ih_r == '0) ih_eff = DIM_W'(1);
    else if (32'(ih_r) > 32'(MAX_HEIGHT)) ih_eff = DIM_W'(MAX_HEIGHT);
    if (kw_r == '0) kw_eff = KDIM_W'(1);
    else if (32'(kw_r) > 32'(MAX_KERNEL)) kw_eff = KDIM_W'(MAX_KERNEL);
    if (kh_r == '0) kh_eff = KDIM_W'(1);
    else if (32'(kh_r) > 32'(MAX_KERNEL)) kh_eff = KDIM_W'(MAX_KERNEL);
  end

  assign ax = kw_eff >> 1;
  assign ay = kh_eff >> 1;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Loads go straight to the stores in the cycle they are accepted.
  always_comb begin
    wr_cmd.img_we = accept && (in_data.action == ACT_LOAD_IMG)
                    && (32'(in_data.row) < 32'(MAX_HEIGHT))
                    && (32'(in_data.col) < 32'(MAX_WIDTH));
    wr_cmd.ker_we = accept && (in_data.action == ACT_LOAD_KER)
                    && (32'(in_data.row) < 32'(MAX_KERNEL))
                    && (32'(in_data.col) < 32'(MAX_KERNEL));
    wr_cmd.img_addr = IMG_AW'(in_data.row) * IMG_AW'(MAX_WIDTH) + IMG_AW'(in_data.col);
    wr_cmd.ker_addr = KER_AW'(in_data.row) * KER_AW'(MAX_KERNEL) + KER_AW'(in_data.col);
    wr_cmd.data     = in_data.value;
  end

  // Image position of the tap around the output pixel.
  always_comb begin
    ty = COORD_W'(row_r) + COORD_W'(ky_r) - COORD_W'(ay);
    tx = COORD_W'(col_r) + COORD_W'(kx_r) - COORD_W'(ax);
    tap_in_img = !ty[COORD_W-1] && (ty[COORD_W-2:0] < (COORD_W-1)'(ih_eff))
              && !tx[COORD_W-1] && (tx[COORD_W-2:0] < (COORD_W-1)'(iw_eff));
    tap.valid    = (state_r == S_RUN) && tap_in_img;
    tap.img_addr = IMG_AW'(ty[ROW_W-1:0]) * IMG_AW'(MAX_WIDTH) + IMG_AW'(tx[COL_W-1:0]);
    tap.ker_addr = KER_AW'(ky_r) * KER_AW'(MAX_KERNEL) + KER_AW'(kx_r);
  end

  assign last_tap = (kx_r == kw_eff - KDIM_W'(1)) && (ky_r == kh_eff - KDIM_W'(1));

  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    kx_nxt    = kx_r;
    ky_nxt    = ky_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    mac_ctl.clear  = 1'b0;
    mac_ctl.finish = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_data.action == ACT_COMPUTE)) begin
          state_nxt     = S_RUN;
          kx_nxt        = '0;
          ky_nxt        = '0;
          row_nxt       = in_data.row;
          col_nxt       = in_data.col;
          mac_ctl.clear = 1'b1;
        end
      end
      S_RUN: begin
        if (last_tap) begin
          state_nxt = S_DRAIN;
          drain_nxt = '0;
        end else if (kx_r == kw_eff - KDIM_W'(1)) begin
          kx_nxt = '0;
          ky_nxt = ky_r + KIDX_W'(1);
        end else begin
          kx_nxt = kx_r + KIDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (drain_r == DRAIN_LAST) begin
          state_nxt      = S_IDLE;
          mac_ctl.finish = 1'b1;
        end else begin
          drain_nxt = drain_r + 2'd1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      drain_r <= '0;
      kx_r    <= '0;
      ky_r    <= '0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
      kx_r    <= kx_nxt;
      ky_r    <= ky_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/c2dzp_mem.sv =====
`default_nettype none

module c2dzp_mem import c2dzp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire wr_cmd_t wr_cmd,
  input  wire tap_t    tap,
  output rd_t          rd
);

  logic signed [VALUE_W-1:0] img_mem [0:IMG_DEPTH-1];
  logic signed [VALUE_W-1:0] ker_mem [0:KER_DEPTH-1];
  logic signed [VALUE_W-1:0] img_q_r;
  logic signed [VALUE_W-1:0] ker_q_r;
  logic                      valid_r;

  always_ff @(posedge clk) begin
    if (wr_cmd.img_we) begin
      img_mem[wr_cmd.img_addr] <= wr_cmd.data;
    end
    img_q_r <= img_mem[tap.img_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_cmd.ker_we) begin
      ker_mem[wr_cmd.ker_addr] <= wr_cmd.data;
    end
    ker_q_r <= ker_mem[tap.ker_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tap.valid;
    end
  end

  assign rd.valid = valid_r;
  assign rd.img   = img_q_r;
  assign rd.ker   = ker_q_r;

endmodule

`default_nettype wire

// ===== rtl/c2dzp_mac.sv =====
`default_nettype none

module c2dzp_mac import c2dzp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rd_t      rd,
  input  wire mac_ctl_t mac_ctl,
  output logic          out_valid,
  output out_item_t     out_data
);

  logic signed [PROD_W-1:0]  prod_r;
  logic                      prod_vld_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [SHIFT_W-1:0] shifted;
  logic                      fits;
  logic                      out_valid_r;
  out_item_t                 out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= rd.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(rd.img) * $signed(rd.ker);
  end

  always_comb begin
    acc_nxt = acc_r;
    if (mac_ctl.clear) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Dropping the fraction bits of a two's complement sum rounds toward
  // minus infinity; the rest must fit in 32 bits or it is clipped.
  always_comb begin
    shifted = acc_r[ACC_W-1:FRAC_W];
    fits    = (shifted[SHIFT_W-1:VALUE_W-1] == '0)
           || (shifted[SHIFT_W-1:VALUE_W-1] == '1);
    out_nxt.saturated = !fits;
    if (fits) begin
      out_nxt.pixel_out = shifted[VALUE_W-1:0];
    end else if (shifted[SHIFT_W-1]) begin
      out_nxt.pixel_out = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      out_nxt.pixel_out = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mac_ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_ctl.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/conv2d_zero_padded.sv =====
// Channel   Handshake                 Payload
// request   start / busy              in_data   (action, row, col, value)
// result    out_valid (strobe)        out_data  (pixel_out, saturated)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A load request is written when accepted and busy stays low. A compute
// request holds busy high while the kernel taps in use pass through the store
// read, product and accumulator registers; the result strobe is high in the
// first cycle with busy low again. The single shared multiplier, at one
// kernel tap per cycle, sets this. Reset is synchronous and active low and
// restores the register defaults; the stores are undefined until loaded.
`default_nettype none

module conv2d_zero_padded import c2dzp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  output out_item_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  wr_cmd_t  wr_cmd;
  tap_t     tap;
  rd_t      rd;
  mac_ctl_t mac_ctl;

  // Registers are simple flops and can take a write in any cycle.
  assign cfg_ready = 1'b1;

  // The sequencer walks the kernel taps row by row and issues one store
  // read per cycle; taps that fall outside the image are issued as
  // bubbles so the multiplier adds nothing for them.
  c2dzp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_cmd    (wr_cmd),
    .tap       (tap),
    .mac_ctl   (mac_ctl)
  );

  // Image and kernel stores with registered read data.
  c2dzp_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_cmd (wr_cmd),
    .tap    (tap),
    .rd     (rd)
  );

  // Shared multiplier, full-width accumulator and output saturation.
  c2dzp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (rd),
    .mac_ctl   (mac_ctl),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/c2dzp_chk.sv =====
`default_nettype none

module c2dzp_chk import c2dzp_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire in_item_t in_data,
  input wire logic     out_valid
);

  logic req_compute;
  logic req_other;

  assign req_compute = start && !busy && (in_data.action == ACT_COMPUTE);
  assign req_other   = start && !busy && (in_data.action != ACT_COMPUTE);

  // Each compute walks all its taps and drains before its strobe, so results never come back to back.
  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result strobes in a row");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req_compute |=> busy)
    else $error("compute request did not raise busy");

  a_load_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req_other |=> !busy)
    else $error("load request raised busy");

  // The result follows the end of a compute and nothing else.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding compute");

  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("compute ended without a result");

endmodule

bind conv2d_zero_padded c2dzp_chk u_c2dzp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid)
);

`default_nettype wire
